FILE: design/nmc_pkg.sv
`default_nettype none
package nmc_pkg;
	localparam int DATA_ADDR_BITS = 7;
	localparam int DATA_DEPTH = 1 << DATA_ADDR_BITS;

	typedef logic [1:0] op_t;
	localparam op_t OP_EXEC = 2'd0;
	localparam op_t OP_CLK  = 2'd1;
	localparam op_t OP_IRQ  = 2'd2;
	localparam op_t OP_RSVD = 2'd3;

	localparam int FL_ST = 0;
	localparam int FL_ZF = 1;
	localparam int FL_CF = 2;
	localparam int FL_VF = 3;
	localparam int FL_SF = 4;
	localparam int FL_NF = 5;

	typedef struct packed {
		op_t         op;
		logic [7:0]  opcode;
		logic [7:0]  operand;
		logic [3:0]  k_port;
		logic [15:0] r_ports;
		logic        line;
	} in_word_t;

	typedef struct packed {
		logic [10:0] next_pc;
		logic [2:0]  cycles;
		logic        o_write;
		logic [4:0]  o_value;
		logic        p_write;
		logic [3:0]  p_value;
		logic        r_write;
		logic [1:0]  r_index;
		logic [3:0]  r_value;
		logic        illegal;
		logic [5:0]  flags;
		logic [3:0]  acc;
	} out_word_t;

	function automatic logic is_legal(input logic [7:0] o);
		is_legal = !(o == 8'h17 || o == 8'h26 || o == 8'h27 ||
			(o >= 8'h28 && o <= 8'h2B) || (o >= 8'h40 && o <= 8'h4B));
	endfunction
endpackage
`default_nettype wire

FILE: design/nmc_if.sv
`default_nettype none
interface nmc_in_if;
	logic               valid;
	logic               ready;
	nmc_pkg::in_word_t  data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface nmc_out_if;
	logic               valid;
	logic               ready;
	nmc_pkg::out_word_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: design/nibble_mcu_instruction_core.sv
// nibble_mcu_instruction_core: 4-bit microcontroller execute core.
// Channel in (sink): one word per instruction or line event. op 0 executes
//   opcode/operand against K and R ports, op 1 gives the timer clock line
//   level, op 2 the external interrupt line level.
// Channel out (source): one word per input word: next fetch address,
//   machine cycles, O/P/R port writes, illegal flag, flags and accumulator.
// Pipeline: the input word is registered into stage 1 on accept, and the result
//   word into the output register when stage 2 fires. Stage 1 issues the data
//   RAM read at the X:Y address (or the fixed xd/xyd slot); stage 2 executes with
//   the read nibble, writes RAM back and loads the output register.
// Throughput: one word per clock when not stalled. The data RAM has one
//   read and one write port; a write in stage 2 to the address read in stage 1 is
//   forwarded, and X/Y changes in stage 2 are forwarded into the stage-1 address.
// Reset: a clearing pass writes zero to all 128 RAM entries with in.ready
//   low. Registers come up at zero, status st set.
// Stall: with the output register full and not taken, the pipeline holds;
//   in.ready drops while stage 2 cannot retire and during the clearing pass.
`default_nettype none
module nibble_mcu_instruction_core (
	input  wire logic clk,
	input  wire logic arst_n,
	nmc_in_if.sink    in,
	nmc_out_if.source out
);
	localparam int AW = nmc_pkg::DATA_ADDR_BITS;

	// clearing pass
	logic [AW:0] clr_q;
	wire clearing = !clr_q[AW];

	// architectural state
	logic [4:0]  page_q;
	logic [5:0]  offset_q;
	logic [1:0]  sp_q;
	logic [15:0] stk_q [4];
	logic [3:0]  a_q, x_q, y_q, th_q, tl_q, sb_q;
	logic [7:0]  en_q;
	logic [2:0]  pend_q;
	logic        clk_lvl_q;
	logic [5:0]  fl_q;

	logic [3:0] ram [nmc_pkg::DATA_DEPTH];
	logic [3:0] rdata_q;

	logic               v_s1;
	nmc_pkg::in_word_t  w_s1;
	logic [AW-1:0]      addr_s1;
	logic               fwd_s1;
	logic [3:0]         fwd_val_s1;

	logic               ov_q;
	nmc_pkg::out_word_t od_q;

	wire adv = !ov_q || out.ready;
	assign in.ready = adv && !clearing;
	wire acc_in = in.valid && in.ready;

	// stage 2 combinational execute
	logic [4:0]  n_page;
	logic [5:0]  n_off;
	logic [1:0]  n_sp;
	logic [3:0]  n_a, n_x, n_y, n_th, n_tl, n_sb;
	logic [7:0]  n_en;
	logic [2:0]  n_pend;
	logic        n_clk;
	logic [5:0]  n_fl;
	logic        st_push;
	logic [1:0]  push_idx;
	logic [15:0] push_val;
	logic        irq_push;
	logic [1:0]  irq_idx;
	logic [15:0] irq_val;
	logic        we;
	logic [AW-1:0] wa;
	logic [3:0]  wd;
	nmc_pkg::out_word_t o;

	logic [3:0] m;
	logic [4:0] r5;
	logic [10:0] pc_a;
	logic [3:0] rn;
	logic [1:0] bi;
	logic [2:0] irq;
	logic [15:0] popv;
	logic [7:0] oc;

	always_comb begin
		oc = w_s1.opcode;
		m = fwd_s1 ? fwd_val_s1 : rdata_q;
		n_page = page_q; n_off = offset_q; n_sp = sp_q;
		n_a = a_q; n_x = x_q; n_y = y_q; n_th = th_q; n_tl = tl_q; n_sb = sb_q;
		n_en = en_q; n_pend = pend_q; n_clk = clk_lvl_q; n_fl = fl_q;
		st_push = 1'b0; push_idx = sp_q; push_val = '0;
		irq_push = 1'b0; irq_idx = sp_q; irq_val = '0;
		we = 1'b0; wa = addr_s1; wd = '0;
		o = '0;
		r5 = '0; pc_a = '0; rn = '0; irq = '0;
		bi = oc[1:0];
		popv = stk_q[sp_q - 2'd1];
		if (w_s1.op == nmc_pkg::OP_CLK) begin
			if (clk_lvl_q != w_s1.line) begin
				n_clk = w_s1.line;
				if (!w_s1.line && en_q[6]) begin
					n_tl = tl_q + 4'd1;
					if (tl_q == 4'hF) begin
						n_th = th_q + 4'd1;
						if (th_q == 4'hF) begin
							n_fl[nmc_pkg::FL_VF] = 1'b1;
							n_pend[1] = 1'b1;
						end
					end
				end
			end
		end else if (w_s1.op == nmc_pkg::OP_IRQ) begin
			if (en_q[2] && !fl_q[nmc_pkg::FL_NF] && w_s1.line) n_pend[2] = 1'b1;
			n_fl[nmc_pkg::FL_NF] = w_s1.line;
		end else if (w_s1.op == nmc_pkg::OP_EXEC && !nmc_pkg::is_legal(oc)) begin
			o.illegal = 1'b1;
		end else if (w_s1.op == nmc_pkg::OP_EXEC) begin
			o.cycles = 3'd1;
			{n_page, n_off} = {page_q, offset_q} + 11'd1;
			if (oc >= 8'hC0) begin
				if (fl_q[nmc_pkg::FL_ST]) n_off = oc[5:0];
				n_fl[nmc_pkg::FL_ST] = 1'b1;
			end else if (oc >= 8'hA0) begin
				r5 = {1'b0, oc[3:0]} - {1'b0, (oc >= 8'hB0) ? a_q : y_q};
				n_fl[nmc_pkg::FL_CF] = r5[4];
				n_fl[nmc_pkg::FL_ZF] = r5[3:0] == 4'd0;
				n_fl[nmc_pkg::FL_ST] = r5[3:0] != 4'd0;
			end else if (oc >= 8'h90) begin
				n_a = oc[3:0]; n_fl[nmc_pkg::FL_ZF] = oc[3:0] == 4'd0;
				n_fl[nmc_pkg::FL_ST] = 1'b1;
			end else if (oc >= 8'h80) begin
				n_y = oc[3:0]; n_fl[nmc_pkg::FL_ZF] = oc[3:0] == 4'd0;
				n_fl[nmc_pkg::FL_ST] = 1'b1;
			end else if (oc >= 8'h70) begin
				r5 = {1'b0, oc[3:0]} + {1'b0, a_q};
				n_fl[nmc_pkg::FL_CF] = r5[4]; n_fl[nmc_pkg::FL_ST] = !r5[4];
				n_a = r5[3:0]; n_fl[nmc_pkg::FL_ZF] = r5[3:0] == 4'd0;
			end else if (oc >= 8'h60) begin
				pc_a = {page_q, offset_q} + 11'd2;
				{n_page, n_off} = pc_a;
				o.cycles = 3'd2;
				if (fl_q[nmc_pkg::FL_ST]) begin
					if (oc < 8'h68) begin
						st_push = 1'b1; push_idx = sp_q; push_val = {5'd0, pc_a};
						n_sp = sp_q + 2'd1;
					end
					n_off = w_s1.operand[5:0];
					n_page = {oc[2:0], w_s1.operand[7:6]};
				end
				n_fl[nmc_pkg::FL_ST] = 1'b1;
			end else if (oc >= 8'h58) begin
				n_x = {1'b0, oc[2:0]}; n_fl[nmc_pkg::FL_ZF] = oc[2:0] == 3'd0;
				n_fl[nmc_pkg::FL_ST] = 1'b1;
			end else if (oc >= 8'h54) begin
				we = 1'b1; wd = y_q; n_y = m;
				n_fl[nmc_pkg::FL_ZF] = m == 4'd0; n_fl[nmc_pkg::FL_ST] = 1'b1;
			end else if (oc >= 8'h50) begin
				we = 1'b1; wd = a_q; n_a = m;
				n_fl[nmc_pkg::FL_ZF] = m == 4'd0; n_fl[nmc_pkg::FL_ST] = 1'b1;
			end else if (oc >= 8'h4C) begin
				n_fl[nmc_pkg::FL_ST] = !a_q[bi];
			end else if (oc >= 8'h38 && oc <= 8'h3B) begin
				n_fl[nmc_pkg::FL_ST] = !m[bi];
			end else if (oc >= 8'h34 && oc <= 8'h37) begin
				we = 1'b1; wd = m & ~(4'd1 << bi); n_fl[nmc_pkg::FL_ST] = 1'b1;
			end else if (oc >= 8'h30 && oc <= 8'h33) begin
				we = 1'b1; wd = m | (4'd1 << bi); n_fl[nmc_pkg::FL_ST] = 1'b1;
			end else begin
				n_fl[nmc_pkg::FL_ST] = 1'b1;
				case (oc)
					8'h01: begin
						o.o_write = 1'b1; o.o_value = {fl_q[nmc_pkg::FL_CF], a_q};
					end
					8'h02: begin o.p_write = 1'b1; o.p_value = a_q; end
					8'h03: begin
						o.r_write = 1'b1; o.r_index = y_q[1:0]; o.r_value = a_q;
					end
					8'h04: n_y = a_q;
					8'h05: n_th = a_q;
					8'h06: n_tl = a_q;
					8'h07: n_sb = a_q;
					8'h08, 8'h0A: begin
						if (oc == 8'h0A) begin we = 1'b1; wd = a_q; end
						n_fl[nmc_pkg::FL_ST] = y_q != 4'hF;
						n_y = y_q + 4'd1;
						n_fl[nmc_pkg::FL_ZF] = y_q == 4'hF;
					end
					8'h09: begin
						n_fl[nmc_pkg::FL_ST] = m != 4'hF;
						we = 1'b1; wd = m + 4'd1;
						n_fl[nmc_pkg::FL_ZF] = m == 4'hF;
					end
					8'h0B: begin
						we = 1'b1; wd = a_q; n_a = m;
						n_fl[nmc_pkg::FL_ZF] = m == 4'd0;
					end
					8'h0C, 8'h0E, 8'h1E: begin
						if (oc == 8'h0C) r5 = {a_q, fl_q[nmc_pkg::FL_CF]};
						else if (oc == 8'h0E)
							r5 = {1'b0, m} + {1'b0, a_q} + {4'd0, fl_q[nmc_pkg::FL_CF]};
						else
							r5 = {1'b0, m} - {1'b0, a_q} - {4'd0, fl_q[nmc_pkg::FL_CF]};
						n_fl[nmc_pkg::FL_CF] = r5[4]; n_fl[nmc_pkg::FL_ST] = !r5[4];
						n_a = r5[3:0]; n_fl[nmc_pkg::FL_ZF] = r5[3:0] == 4'd0;
					end
					8'h0D: begin n_a = m; n_fl[nmc_pkg::FL_ZF] = m == 4'd0; end
					8'h0F, 8'h1F, 8'h2F: begin
						if (oc == 8'h0F) rn = a_q & m;
						else if (oc == 8'h1F) rn = a_q | m;
						else rn = a_q ^ m;
						n_a = rn; n_fl[nmc_pkg::FL_ZF] = rn == 4'd0;
						n_fl[nmc_pkg::FL_ST] = rn != 4'd0;
					end
					8'h10, 8'h11: begin
						r5 = {1'b0, a_q};
						if (fl_q[nmc_pkg::FL_CF] || a_q > 4'd9)
							r5 = r5 + ((oc == 8'h10) ? 5'd6 : 5'd10);
						n_fl[nmc_pkg::FL_CF] = r5[4]; n_fl[nmc_pkg::FL_ST] = !r5[4];
						n_a = r5[3:0];
					end
					8'h12, 8'h13, 8'h14, 8'h15, 8'h16: begin
						if (oc == 8'h12) rn = w_s1.k_port;
						else if (oc == 8'h13) rn = w_s1.r_ports[{y_q[1:0], 2'b00} +: 4];
						else if (oc == 8'h14) rn = y_q;
						else if (oc == 8'h15) rn = th_q;
						else rn = tl_q;
						n_a = rn; n_fl[nmc_pkg::FL_ZF] = rn == 4'd0;
					end
					8'h18: begin
						n_fl[nmc_pkg::FL_ST] = y_q != 4'd0; n_y = y_q - 4'd1;
					end
					8'h19: begin
						n_fl[nmc_pkg::FL_ST] = m != 4'd0;
						we = 1'b1; wd = m - 4'd1;
						n_fl[nmc_pkg::FL_ZF] = m == 4'd1;
					end
					8'h1A: begin
						we = 1'b1; wd = a_q;
						n_fl[nmc_pkg::FL_ST] = y_q != 4'd0; n_y = y_q - 4'd1;
						n_fl[nmc_pkg::FL_ZF] = y_q == 4'd1;
					end
					8'h1B: begin
						n_x = a_q; n_a = x_q; n_fl[nmc_pkg::FL_ZF] = x_q == 4'd0;
					end
					8'h1C: begin
						n_fl[nmc_pkg::FL_CF] = a_q[0]; n_fl[nmc_pkg::FL_ST] = !a_q[0];
						n_a = {fl_q[nmc_pkg::FL_CF], a_q[3:1]};
						n_fl[nmc_pkg::FL_ZF] = {fl_q[nmc_pkg::FL_CF], a_q[3:1]} == 4'd0;
					end
					8'h1D: begin we = 1'b1; wd = a_q; end
					8'h20, 8'h22, 8'h24: begin
						rn = w_s1.r_ports[{y_q[3:2], 2'b00} +: 4];
						if (oc == 8'h24) n_fl[nmc_pkg::FL_ST] = !rn[y_q[1:0]];
						else begin
							o.r_write = 1'b1; o.r_index = y_q[3:2];
							o.r_value = (oc == 8'h20) ? (rn | (4'd1 << y_q[1:0]))
								: (rn & ~(4'd1 << y_q[1:0]));
						end
					end
					8'h21: n_fl[nmc_pkg::FL_CF] = 1'b1;
					8'h23: n_fl[nmc_pkg::FL_CF] = 1'b0;
					8'h25: n_fl[nmc_pkg::FL_ST] = !fl_q[nmc_pkg::FL_NF];
					8'h2C, 8'h3C: begin
						n_sp = sp_q - 2'd1;
						n_off = popv[5:0]; n_page = popv[10:6];
						if (oc == 8'h3C) begin
							n_fl[nmc_pkg::FL_CF] = popv[13];
							n_fl[nmc_pkg::FL_ZF] = popv[14];
							n_fl[nmc_pkg::FL_ST] = popv[15];
						end
					end
					8'h2D: begin
						n_a = 4'd0 - a_q; n_fl[nmc_pkg::FL_ST] = a_q != 4'd0;
					end
					8'h2E: begin
						r5 = {1'b0, m} - {1'b0, a_q};
						n_fl[nmc_pkg::FL_CF] = r5[4];
						n_fl[nmc_pkg::FL_ZF] = r5[3:0] == 4'd0;
						n_fl[nmc_pkg::FL_ST] = r5[3:0] != 4'd0;
					end
					8'h3D: begin
						n_page = w_s1.operand[4:0]; n_off = {a_q, 2'b00};
						o.cycles = 3'd2;
					end
					8'h3E, 8'h3F: begin
						{n_page, n_off} = {page_q, offset_q} + 11'd2;
						n_en = (oc == 8'h3E) ? (en_q | w_s1.operand)
							: (en_q & ~w_s1.operand);
						o.cycles = 3'd2;
					end
					default: ;
				endcase
			end
			// interrupt entry, pushed above any call return word
			irq = n_pend & n_en[2:0];
			if (irq != 3'd0) begin
				irq_push = 1'b1; irq_idx = n_sp;
				irq_val = {n_fl[nmc_pkg::FL_ST], n_fl[nmc_pkg::FL_ZF],
					n_fl[nmc_pkg::FL_CF], 2'b00, n_page, n_off};
				n_sp = n_sp + 2'd1;
				n_off = irq[2] ? 6'd2 : (irq[1] ? 6'd4 : 6'd6);
				n_page = '0;
				n_fl[nmc_pkg::FL_ST] = 1'b1;
				n_pend = '0;
				o.cycles = o.cycles + 3'd3;
			end
		end
		o.next_pc = {n_page, n_off};
		o.flags = n_fl;
		o.acc = n_a;
	end

	wire fire2 = v_s1 && adv;

	// stage 1 address using forwarded X/Y
	logic [3:0] fx, fy;
	logic [AW-1:0] addr_in;
	logic [7:0] ioc;
	always_comb begin
		fx = (fire2) ? n_x : x_q;
		fy = (fire2) ? n_y : y_q;
		ioc = in.data.opcode;
		if (ioc >= 8'h50 && ioc <= 8'h57)
			addr_in = AW'({5'd0, ioc[2:0]});
		else
			addr_in = AW'({fx, fy});
	end

	// memory
	logic [AW-1:0] ra;
	always_comb ra = clearing ? clr_q[AW-1:0] : addr_in;
	always_ff @(posedge clk) begin
		if (clearing) ram[clr_q[AW-1:0]] <= '0;
		else if (fire2 && we) ram[wa] <= wd;
		if (acc_in) rdata_q <= ram[addr_in];
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			w_s1 <= in.data;
			addr_s1 <= addr_in;
			fwd_s1 <= fire2 && we && (wa == addr_in);
			fwd_val_s1 <= wd;
		end else if (fire2 && we && wa == addr_s1) begin
			fwd_s1 <= 1'b1;
			fwd_val_s1 <= wd;
		end
		if (fire2) od_q <= o;
		if (clearing) stk_q[clr_q[1:0]] <= '0;
		if (fire2 && st_push) stk_q[push_idx] <= push_val;
		if (fire2 && irq_push) stk_q[irq_idx] <= irq_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			v_s1 <= 1'b0; ov_q <= 1'b0;
			page_q <= '0; offset_q <= '0; sp_q <= '0;
			a_q <= '0; x_q <= '0; y_q <= '0; th_q <= '0; tl_q <= '0; sb_q <= '0;
			en_q <= '0; pend_q <= '0; clk_lvl_q <= 1'b0;
			fl_q <= 6'b000001;
		end else begin
			if (clearing) clr_q <= clr_q + 1'b1;
			if (adv) v_s1 <= acc_in;
			if (fire2) ov_q <= 1'b1;
			else if (out.ready) ov_q <= 1'b0;
			if (fire2) begin
				page_q <= n_page; offset_q <= n_off; sp_q <= n_sp;
				a_q <= n_a; x_q <= n_x; y_q <= n_y; th_q <= n_th; tl_q <= n_tl;
				sb_q <= n_sb; en_q <= n_en; pend_q <= n_pend; clk_lvl_q <= n_clk;
				fl_q <= n_fl;
			end
		end
	end

	// return stack reset to zero: cleared alongside the RAM pass
	logic unused_ok;
	assign unused_ok = ^{sb_q, ra};

	assign out.valid = ov_q;
	assign out.data = od_q;
endmodule
`default_nettype wire

FILE: design/nmc_checker.sv
`default_nettype none
module nmc_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire nmc_pkg::out_word_t out_data
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped or changed while stalled");
	a_ill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.illegal |-> out_data.cycles == 3'd0)
		else $error("illegal word reports cycles");
	a_ports: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.o_write |-> out_data.o_value == 5'd0)
		else $error("o_value without write");
	a_cyc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.cycles <= 3'd5)
		else $error("cycle count out of range");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while result stalled");
endmodule

bind nibble_mcu_instruction_core nmc_checker u_nmc_checker (
	.clk(clk), .arst_n(arst_n), .in_ready(in.ready),
	.out_valid(out.valid), .out_ready(out.ready), .out_data(out.data)
);
`default_nettype wire
